[src/mccol_pkg.sv]
`default_nettype none
package mccol_pkg;

    // Store size, axis width and the derived widths.
    localparam int POINT_CAPACITY = 256;
    localparam int AXIS_BITS      = 16;
    localparam int IDX_W          = $clog2(POINT_CAPACITY);
    localparam int CNT_W          = $clog2(POINT_CAPACITY + 1);
    localparam int SQ_W           = 2 * AXIS_BITS;
    localparam int SUM_W          = SQ_W + 2;
    localparam int CFG_W          = 34;
    localparam int CNTDN_W        = 16;

    // Item kinds.
    localparam logic [1:0] FUNC_MAG     = 2'd0;
    localparam logic [1:0] FUNC_ACC     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_SPREAD_SQ    = 2'd0;
    localparam logic [1:0] REG_JUMP_SQ      = 2'd1;
    localparam logic [1:0] REG_AVG_COUNT    = 2'd2;
    localparam logic [1:0] REG_ACCEL_PAIRED = 2'd3;

    // Result status codes.
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef logic signed [AXIS_BITS-1:0] t_axis;

    typedef struct packed {
        t_axis x;
        t_axis y;
        t_axis z;
    } t_point;

endpackage
`default_nettype wire

[src/mag_cal_spread_sample_collector_unit.sv]
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_func, i_sample_x/y/z
// out       output     o_out_valid / i_out_ready o_status, o_point_count, o_mag_*, o_acc_*
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A restart or ignored item is finished when it is accepted; an accel sample
// goes through the accel state. A magnetometer sample circulates the whole ring
// of stored points once, one point per cycle, then drains the distance pipeline
// and reaches a decision: it is dropped as too close, or stored and reported in
// the output state; a sample against a full store goes straight to the output state.
// Synchronous active-low reset empties the store and restores register defaults.
// A stalled result is held in the output register; the next item is taken
// meanwhile and only waits if it also produces a result.
module mag_cal_spread_sample_collector_unit
    import mccol_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_func,
    input  wire logic signed [AXIS_BITS-1:0] i_sample_x,
    input  wire logic signed [AXIS_BITS-1:0] i_sample_y,
    input  wire logic signed [AXIS_BITS-1:0] i_sample_z,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_status,
    output logic [CNT_W-1:0]      o_point_count,
    output logic signed [AXIS_BITS-1:0] o_mag_x,
    output logic signed [AXIS_BITS-1:0] o_mag_y,
    output logic signed [AXIS_BITS-1:0] o_mag_z,
    output logic signed [AXIS_BITS-1:0] o_acc_x,
    output logic signed [AXIS_BITS-1:0] o_acc_y,
    output logic signed [AXIS_BITS-1:0] o_acc_z,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]         r_state;
    logic [CFG_W-1:0]   r_spread_sq, r_jump_sq;
    logic [CNTDN_W-1:0] r_avg_count, r_countdown;
    logic               r_paired;
    logic [CNT_W-1:0]   r_count;
    t_point             r_avg, r_smp, r_acc;
    logic [IDX_W-1:0]   r_step;
    logic [1:0]         r_wait;
    logic               r_hit;
    logic               r_res_status;
    logic               r_out_valid;
    t_point             w_cell [POINT_CAPACITY];
    t_point             w_dist_b;
    logic               w_tag;
    logic [SUM_W-1:0]   w_sum;
    logic               w_sum_tag;
    logic [CNTDN_W-1:0] w_rearm;
    logic               w_accept;
    logic               w_out_free;
    t_point             w_half;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_rearm     = (r_avg_count == '0) ? CNTDN_W'(1) : r_avg_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_sq <= '0;
            r_jump_sq   <= '0;
            r_avg_count <= CNTDN_W'(1);
            r_paired    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPREAD_SQ:    r_spread_sq <= i_cfg_data;
                REG_JUMP_SQ:      r_jump_sq   <= i_cfg_data;
                REG_AVG_COUNT:    r_avg_count <= i_cfg_data[CNTDN_W-1:0];
                REG_ACCEL_PAIRED: r_paired    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Ring of stored points; cell 0 is the read head.
    genvar gi;
    generate
        for (gi = 0; gi < POINT_CAPACITY; gi++) begin : g_ring
            mccol_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (r_state == ST_SCAN),
                .i_load    ((r_state == ST_DECIDE) && !r_hit &&
                            (r_count[IDX_W-1:0] == IDX_W'(gi))),
                .i_next    (w_cell[(gi + 1) % POINT_CAPACITY]),
                .i_load_pt (r_smp),
                .o_point   (w_cell[gi])
            );
        end
    endgenerate

    // Shared squared-distance unit: against the running average or the ring head.
    assign w_dist_b = (r_state == ST_ACC) ? r_avg : w_cell[0];
    assign w_tag    = (r_state == ST_SCAN) && ({1'b0, r_step} < r_count);

    mccol_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_smp),
        .i_b     (w_dist_b),
        .i_tag   (w_tag),
        .o_sum   (w_sum),
        .o_tag   (w_sum_tag)
    );

    // Halved sum of average and sample, rounded toward minus infinity.
    always_comb begin
        logic signed [AXIS_BITS:0] sx, sy, sz;
        sx = {r_avg.x[AXIS_BITS-1], r_avg.x} + {r_smp.x[AXIS_BITS-1], r_smp.x};
        sy = {r_avg.y[AXIS_BITS-1], r_avg.y} + {r_smp.y[AXIS_BITS-1], r_smp.y};
        sz = {r_avg.z[AXIS_BITS-1], r_avg.z} + {r_smp.z[AXIS_BITS-1], r_smp.z};
        w_half.x = sx[AXIS_BITS:1];
        w_half.y = sy[AXIS_BITS:1];
        w_half.z = sz[AXIS_BITS:1];
    end

    // Sample register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp <= '{x: i_sample_x, y: i_sample_y, z: i_sample_z};
        end
    end

    // Sequencer and collector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_avg       <= '0;
            r_countdown <= '0;
            r_step      <= '0;
            r_wait      <= '0;
            r_hit       <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_step <= '0;
                        r_wait <= '0;
                        r_hit  <= 1'b0;
                        case (i_func)
                            FUNC_RESTART: begin
                                r_count     <= '0;
                                r_avg       <= '0;
                                r_countdown <= r_paired ? w_rearm : '0;
                            end
                            FUNC_ACC: begin
                                if (r_countdown != '0) begin
                                    r_state <= ST_ACC;
                                end
                            end
                            FUNC_MAG: begin
                                if (!r_paired || r_countdown == '0) begin
                                    r_acc <= r_paired ? r_avg : '0;
                                    if (r_paired) begin
                                        r_avg       <= '0;
                                        r_countdown <= w_rearm;
                                    end
                                    if (r_count == CNT_W'(POINT_CAPACITY)) begin
                                        r_res_status <= STATUS_FULL;
                                        r_state      <= ST_OUT;
                                    end else begin
                                        r_state <= ST_SCAN;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ACC: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd2) begin
                        if (w_sum < r_jump_sq) begin
                            r_avg       <= w_half;
                            r_countdown <= r_countdown - CNTDN_W'(1);
                        end else begin
                            r_avg       <= r_smp;
                            r_countdown <= w_rearm - CNTDN_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    r_step <= r_step + IDX_W'(1);
                    if (r_step == IDX_W'(POINT_CAPACITY - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd1) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_hit) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_count      <= r_count + CNT_W'(1);
                        r_res_status <= STATUS_STORED;
                        r_state      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // Any stored point closer than the spread drops the sample.
            if (w_sum_tag && (w_sum < r_spread_sq)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            o_status      <= r_res_status;
            o_point_count <= r_count;
            o_mag_x       <= r_smp.x;
            o_mag_y       <= r_smp.y;
            o_mag_z       <= r_smp.z;
            o_acc_x       <= r_acc.x;
            o_acc_y       <= r_acc.y;
            o_acc_z       <= r_acc.z;
        end
    end

    assign o_out_valid = r_out_valid;

    // The point count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POINT_CAPACITY))
        else $error("point count beyond capacity");

    // A decision without a close hit appends exactly one point.
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && !r_hit) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance the count");

    // The ring is back in its home alignment when the scan ends.
    a_scan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_step == '0))
        else $error("scan ended off alignment");

    // A full store is reported without any scan.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != CNT_W'(POINT_CAPACITY)))
        else $error("scan started on a full store");

endmodule
`default_nettype wire

[src/mccol_cell.sv]
`default_nettype none
module mccol_cell
    import mccol_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire logic   i_load,
    input  wire t_point i_next,
    input  wire t_point i_load_pt,
    output t_point      o_point
);

    t_point r_point;

    // One stored point: loaded on append, otherwise passed along the ring.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_point <= i_load_pt;
        end else if (i_shift) begin
            r_point <= i_next;
        end
    end

    assign o_point = r_point;

endmodule
`default_nettype wire

[src/mccol_dist.sv]
`default_nettype none
module mccol_dist
    import mccol_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_point           i_a,
    input  wire t_point           i_b,
    input  wire logic             i_tag,
    output logic [SUM_W-1:0]      o_sum,
    output logic                  o_tag
);

    logic signed [AXIS_BITS:0] n_dx, n_dy, n_dz;
    logic [AXIS_BITS-1:0]      n_mx, n_my, n_mz;
    logic [SQ_W-1:0]           r_sqx, r_sqy, r_sqz;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_tag1, r_tag2;

    // Differences and their magnitudes; the magnitude always fits the axis width.
    always_comb begin
        n_dx = {i_a.x[AXIS_BITS-1], i_a.x} - {i_b.x[AXIS_BITS-1], i_b.x};
        n_dy = {i_a.y[AXIS_BITS-1], i_a.y} - {i_b.y[AXIS_BITS-1], i_b.y};
        n_dz = {i_a.z[AXIS_BITS-1], i_a.z} - {i_b.z[AXIS_BITS-1], i_b.z};
        n_mx = n_dx[AXIS_BITS] ? AXIS_BITS'(-n_dx) : n_dx[AXIS_BITS-1:0];
        n_my = n_dy[AXIS_BITS] ? AXIS_BITS'(-n_dy) : n_dy[AXIS_BITS-1:0];
        n_mz = n_dz[AXIS_BITS] ? AXIS_BITS'(-n_dz) : n_dz[AXIS_BITS-1:0];
    end

    // First stage squares, second stage sums.
    always_ff @(posedge i_clk) begin
        r_sqx <= n_mx * n_mx;
        r_sqy <= n_my * n_my;
        r_sqz <= n_mz * n_mz;
        r_sum <= {2'b00, r_sqx} + {2'b00, r_sqy} + {2'b00, r_sqz};
    end

    // The tag follows the data through both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= 1'b0;
            r_tag2 <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag2;

endmodule
`default_nettype wire
